// ----- rtl/assert_macros.svh -----
// Assertion helpers. The calling module must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checks disabled while reset is asserted
`define CHK_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checks disabled while reset is asserted
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/desp_pkg.sv -----
`default_nettype none
package desp_pkg;

	localparam int NAME_LIMIT_DEF   = 255;
	localparam int RES_QUEUE_DEPTH  = 4;
	localparam logic [15:0] RECORD_LIMIT_RST = 16'd64;

	// entry type bytes
	localparam logic [7:0] ET_END    = 8'h00;
	localparam logic [7:0] ET_FILE   = 8'h85;
	localparam logic [7:0] ET_STREAM = 8'hC0;
	localparam logic [7:0] ET_NAME   = 8'hC1;

	// field positions inside a 32-byte entry
	localparam logic [4:0] ATTR_OFS     = 5'd4;
	localparam logic [4:0] CLUSTER_OFS  = 5'd20;
	localparam logic [4:0] LENGTH_OFS   = 5'd24;
	localparam logic [4:0] NAME_CHR_OFS = 5'd2;
	localparam int         ATTR_DIR_BIT = 4;

	typedef enum logic [1:0] {
		KIND_CHAR   = 2'd0,
		KIND_RECORD = 2'd1,
		KIND_END    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		EK_SKIP   = 2'd0,
		EK_FILE   = 2'd1,
		EK_STREAM = 2'd2,
		EK_NAME   = 2'd3
	} entry_kind_t;

	typedef struct packed {
		logic [4:0]  entry_offset;
		entry_kind_t entry_kind;
		logic        group_open;
		logic        name_stopped;
		logic [7:0]  low_byte_hold;
		logic [7:0]  chars_taken;
		logic        dir_flag;
		logic [31:0] cluster_acc;
		logic [63:0] length_acc;
		logic [15:0] records_done;
		logic        halted;
	} parse_state_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  name_char;
		logic        is_directory;
		logic [31:0] start_cluster;
		logic [63:0] data_length;
		logic [7:0]  name_length;
		logic        last;
	} result_t;

endpackage
`default_nettype wire

// ----- rtl/desp_in_if.sv -----
`default_nettype none
interface desp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_dir;
	logic       last_of_cluster;

	modport source (output valid, data_byte, start_of_dir, last_of_cluster, input ready);
	modport sink (input valid, data_byte, start_of_dir, last_of_cluster, output ready);
endinterface
`default_nettype wire

// ----- rtl/desp_out_if.sv -----
`default_nettype none
interface desp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  name_char;
	logic        is_directory;
	logic [31:0] start_cluster;
	logic [63:0] data_length;
	logic [7:0]  name_length;
	logic        last;

	modport source (output valid, kind, name_char, is_directory, start_cluster, data_length,
		name_length, last, input ready);
	modport sink (input valid, kind, name_char, is_directory, start_cluster, data_length,
		name_length, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/dir_entry_set_parser.sv -----
// exFAT directory entry-set parser.
// bytes   : one raw directory byte per transfer (data_byte, start_of_dir,
//           last_of_cluster), valid/ready handshake.
// results : name characters, file records and the end-of-directory mark,
//           one result per transfer; last marks the final result of a byte.
// record_limit_we/record_limit_wdata : record limit, to be written only
// when idle; the block itself does not enforce this. Throughput: one byte
// per cycle while the queue has room. A byte that yields two results needs
// two output transfers, so sustained rate is set by the output port, one
// result per cycle. Path: a byte is held in the input register until the
// queue has room for a pair; its results are then written to a four-entry
// result queue and offered from its head.
// Input ready depends only on registered state (input stage and queue
// fill), never combinationally on results.ready.
// Stall: while results.ready is low the queue fills; once it cannot take a
// pair of results the input stage holds and bytes.ready drops.
// Reset: parse state cleared, record limit back to 64, queue empty.
`default_nettype none
module dir_entry_set_parser #(
	parameter int NAME_LIMIT = desp_pkg::NAME_LIMIT_DEF
) (
	input  var logic          clk,
	input  var logic          arst_n,
	desp_in_if.sink           bytes,
	desp_out_if.source        results,
	input  var logic          record_limit_we,
	input  var logic [15:0]   record_limit_wdata
);
	import desp_pkg::*;
	`include "assert_macros.svh"

	// input stage
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         sod_s1;
	logic         loc_s1;

	logic [15:0]  record_limit_q;
	parse_state_t st_q, st_nxt;

	logic [1:0]   step_n;
	result_t      res_a, res_b;
	logic         q_room;
	logic         fire;
	result_t      head;

	// the input stage hands its byte to the parser when the queue has room
	assign fire        = valid_s1 && q_room;
	assign bytes.ready = !valid_s1 || q_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.data_byte;
			sod_s1  <= bytes.start_of_dir;
			loc_s1  <= bytes.last_of_cluster;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_limit_q <= RECORD_LIMIT_RST;
		end else if (record_limit_we) begin
			record_limit_q <= record_limit_wdata;
		end
	end

	// parse state advances once per byte handed over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= st_nxt;
		end
	end

	desp_step #(
		.NAME_LIMIT(NAME_LIMIT)
	) u_step (
		.st              (st_q),
		.data_byte       (byte_s1),
		.start_of_dir    (sod_s1),
		.last_of_cluster (loc_s1),
		.record_limit    (record_limit_q),
		.st_nxt          (st_nxt),
		.res_n           (step_n),
		.res_a           (res_a),
		.res_b           (res_b)
	);

	desp_res_queue #(
		.DEPTH(RES_QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (fire ? step_n : 2'd0),
		.push_a     (res_a),
		.push_b     (res_b),
		.room       (q_room),
		.head_valid (results.valid),
		.head_ready (results.ready),
		.head       (head)
	);

	assign results.kind          = head.kind;
	assign results.name_char     = head.name_char;
	assign results.is_directory  = head.is_directory;
	assign results.start_cluster = head.start_cluster;
	assign results.data_length   = head.data_length;
	assign results.name_length   = head.name_length;
	assign results.last          = head.last;

	// a halted parser stays silent until the next start of directory
	`CHK_NOW(a_halt_quiet, fire && st_q.halted && !sod_s1, step_n == 2'd0, "output while halted")
	// the record count only climbs within a directory
	`CHK_NEXT(a_rec_mono, fire && !sod_s1, st_q.records_done >= $past(st_q.records_done), "record count fell")
endmodule
`default_nettype wire

// ----- rtl/desp_step.sv -----
`default_nettype none
module desp_step #(
	parameter int NAME_LIMIT = desp_pkg::NAME_LIMIT_DEF
) (
	input  var desp_pkg::parse_state_t st,
	input  var logic [7:0]             data_byte,
	input  var logic                   start_of_dir,
	input  var logic                   last_of_cluster,
	input  var logic [15:0]            record_limit,
	output desp_pkg::parse_state_t     st_nxt,
	output logic [1:0]                 res_n,
	output desp_pkg::result_t          res_a,
	output desp_pkg::result_t          res_b
);
	import desp_pkg::*;

	function automatic result_t make_record(parse_state_t s);
		result_t r;
		r               = '0;
		r.kind          = KIND_RECORD;
		r.is_directory  = s.dir_flag;
		r.start_cluster = s.cluster_acc;
		r.data_length   = s.length_acc;
		r.name_length   = s.chars_taken;
		return r;
	endfunction

	parse_state_t s;
	result_t      pre_r, mid_r, post_r;
	logic         pre_v, mid_v, post_v;
	logic [4:0]   off;

	always_comb begin
		s      = start_of_dir ? '0 : st;
		pre_v  = 1'b0;
		mid_v  = 1'b0;
		post_v = 1'b0;
		pre_r  = '0;
		mid_r  = '0;
		post_r = '0;
		off    = s.entry_offset;

		if (!s.halted) begin
			if (off == '0) begin
				if (s.records_done >= record_limit) begin
					s.halted     = 1'b1;
					s.group_open = 1'b0;
				end else begin
					// anything but stream/name closes the open group
					if (s.group_open && data_byte != ET_STREAM && data_byte != ET_NAME) begin
						pre_v        = 1'b1;
						pre_r        = make_record(s);
						s.group_open = 1'b0;
						if (s.records_done != 16'hFFFF)
							s.records_done = s.records_done + 16'd1;
						if (s.records_done >= record_limit)
							s.halted = 1'b1;
					end
					s.entry_kind = EK_SKIP;
					if (!s.halted) begin
						if (data_byte == ET_END) begin
							mid_v      = 1'b1;
							mid_r.kind = KIND_END;
							s.halted   = 1'b1;
						end else if (data_byte == ET_FILE) begin
							s.group_open  = 1'b1;
							s.dir_flag    = 1'b0;
							s.cluster_acc = '0;
							s.length_acc  = '0;
							s.chars_taken = '0;
							s.entry_kind  = EK_FILE;
						end else if (data_byte == ET_STREAM && s.group_open) begin
							s.entry_kind = EK_STREAM;
						end else if (data_byte == ET_NAME && s.group_open) begin
							s.entry_kind   = EK_NAME;
							s.name_stopped = 1'b0;
						end
					end
				end
			end else if (s.entry_kind == EK_FILE) begin
				if (off == ATTR_OFS)
					s.dir_flag = data_byte[ATTR_DIR_BIT];
			end else if (s.entry_kind == EK_STREAM) begin
				if (off >= CLUSTER_OFS && off < LENGTH_OFS)
					s.cluster_acc[{off[1:0], 3'b000} +: 8] = data_byte;
				else if (off >= LENGTH_OFS)
					s.length_acc[{off[2:0], 3'b000} +: 8] = data_byte;
			end else if (s.entry_kind == EK_NAME && off >= NAME_CHR_OFS) begin
				if (!off[0]) begin
					s.low_byte_hold = data_byte;
				end else if (!s.name_stopped) begin
					if (s.low_byte_hold == '0 && data_byte == '0) begin
						s.name_stopped = 1'b1;
					end else if (s.chars_taken < 8'(NAME_LIMIT)) begin
						mid_v           = 1'b1;
						mid_r.kind      = KIND_CHAR;
						mid_r.name_char = s.low_byte_hold;
						s.chars_taken   = s.chars_taken + 8'd1;
					end
				end
			end
			s.entry_offset = off + 5'd1;
		end

		if (last_of_cluster) begin
			if (!s.halted && s.group_open) begin
				post_v       = 1'b1;
				post_r       = make_record(s);
				s.group_open = 1'b0;
				if (s.records_done != 16'hFFFF)
					s.records_done = s.records_done + 16'd1;
				if (s.records_done >= record_limit)
					s.halted = 1'b1;
			end
			s.entry_offset = '0;
		end

		st_nxt = s;
		res_n  = {1'b0, pre_v} + {1'b0, mid_v} + {1'b0, post_v};
		// pack the (at most two) results into order
		res_a  = pre_v ? pre_r : (mid_v ? mid_r : post_r);
		res_b  = (pre_v && mid_v) ? mid_r : post_r;
		res_a.last = (res_n == 2'd1);
		res_b.last = 1'b1;
	end
endmodule
`default_nettype wire

// ----- rtl/desp_res_queue.sv -----
`default_nettype none
module desp_res_queue #(
	parameter int DEPTH = desp_pkg::RES_QUEUE_DEPTH
) (
	input  var logic              clk,
	input  var logic              arst_n,
	input  var logic [1:0]        push_n,
	input  var desp_pkg::result_t push_a,
	input  var desp_pkg::result_t push_b,
	output logic                  room,
	output logic                  head_valid,
	input  var logic              head_ready,
	output desp_pkg::result_t     head
);
	import desp_pkg::*;
	`include "assert_macros.svh"

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	result_t       mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q, wr_nxt;
	logic [CW-1:0] cnt_q;
	logic          pop;

	assign wr_nxt     = ptr_inc(wr_q);
	assign pop        = head_valid && head_ready;
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	// room for a worst-case pair, judged on the registered count only
	assign room       = (cnt_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem_q[wr_q] <= push_a;
		if (push_n == 2'd2)
			mem_q[wr_nxt] <= push_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_n == 2'd1)
				wr_q <= wr_nxt;
			else if (push_n == 2'd2)
				wr_q <= ptr_inc(wr_nxt);
			if (pop)
				rd_q <= ptr_inc(rd_q);
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

	`CHK_NOW(a_no_overflow, push_n != 2'd0, (CW+1)'(cnt_q) + (CW+1)'(push_n) <= (CW+1)'(DEPTH), "result queue overflow")
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Directory entry-set parser testbench.
// Bytes go in through the byte channel, and a model of the parser held here
// works out the results that each accepted byte should give. Every result
// transfer is checked field by field against the oldest result still owed.
module tb;
	import desp_pkg::*;

	localparam int NAME_CAP = NAME_LIMIT_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD_CYCLES = 300;
	// time for a byte to pass the input register and result queue, plus margin
	localparam int QUIET_CYCLES = 6;

	// one 32-byte directory entry, byte i at [i]
	typedef logic [31:0][7:0] entry_t;

	logic clk;
	logic arst_n;
	logic limit_we;
	logic [15:0] limit_wdata;

	desp_in_if byte_if ();
	desp_out_if res_if ();

	dir_entry_set_parser #(
		.NAME_LIMIT(NAME_CAP)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(byte_if.sink),
		.results(res_if.source),
		.record_limit_we(limit_we),
		.record_limit_wdata(limit_wdata)
	);

	// ------------------------------------------------------------------
	// Parser model state (mirrors the block, kept in step at each byte
	// transfer) and the results still owed by the block.
	// ------------------------------------------------------------------
	logic [4:0]  cur_offset;
	entry_kind_t cur_entry;
	logic        group_is_open;
	logic        name_done;
	logic [7:0]  lo_hold;
	logic [7:0]  name_count;
	logic        dir_bit;
	logic [31:0] clus_start;
	logic [63:0] byte_length;
	logic [15:0] records_out;
	logic        parse_halted;
	logic [15:0] record_limit_val;

	result_t byte_results[$];
	result_t pending_results[$];

	int errors = 0;
	int cycle_count = 0;
	int bytes_parsed = 0;

	// stimulus shaping
	int burst_left = 0;
	int cluster_left = 64;
	bit gapless = 1'b0;
	bit cluster_cuts = 1'b0;
	bit sod_pending = 1'b0;
	int hold_reqs = 0;
	int holds_done = 0;
	int pace_count = 0;
	int pace_mode = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_parser();
		cur_offset = '0;
		cur_entry = EK_SKIP;
		group_is_open = 1'b0;
		name_done = 1'b0;
		lo_hold = '0;
		name_count = '0;
		dir_bit = 1'b0;
		clus_start = '0;
		byte_length = '0;
		records_out = '0;
		parse_halted = 1'b0;
	endfunction

	// Close the open group with a file record; reaching the limit halts
	// the parser without an end mark.
	function automatic void close_group();
		result_t r;
		r = '0;
		r.kind = KIND_RECORD;
		r.is_directory = dir_bit;
		r.start_cluster = clus_start;
		r.data_length = byte_length;
		r.name_length = name_count;
		byte_results.push_back(r);
		group_is_open = 1'b0;
		if (records_out != 16'hFFFF)
			records_out++;
		if (records_out >= record_limit_val)
			parse_halted = 1'b1;
	endfunction

	// Advance the model by one byte and queue what it should produce.
	// Returns 1 when the byte was ignored because the parser had halted.
	function automatic bit parse_byte(input logic [7:0] b, input logic sod, input logic loc);
		result_t r;
		bit ignored;
		if (sod)
			clear_parser();
		ignored = parse_halted;
		if (!parse_halted) begin
			if (cur_offset == 5'd0) begin
				// entry type byte
				if (records_out >= record_limit_val) begin
					// limit lowered to or below the count: stop, open group is lost
					parse_halted = 1'b1;
					group_is_open = 1'b0;
				end else begin
					if (group_is_open && b != ET_STREAM && b != ET_NAME)
						close_group();
					cur_entry = EK_SKIP;
					if (!parse_halted) begin
						if (b == ET_END) begin
							r = '0;
							r.kind = KIND_END;
							byte_results.push_back(r);
							parse_halted = 1'b1;
						end else if (b == ET_FILE) begin
							group_is_open = 1'b1;
							dir_bit = 1'b0;
							clus_start = '0;
							byte_length = '0;
							name_count = '0;
							cur_entry = EK_FILE;
						end else if (b == ET_STREAM && group_is_open) begin
							cur_entry = EK_STREAM;
						end else if (b == ET_NAME && group_is_open) begin
							cur_entry = EK_NAME;
							name_done = 1'b0;
						end
					end
				end
			end else if (cur_entry == EK_FILE) begin
				if (cur_offset == ATTR_OFS)
					dir_bit = b[ATTR_DIR_BIT];
			end else if (cur_entry == EK_STREAM) begin
				if (cur_offset >= CLUSTER_OFS && cur_offset < LENGTH_OFS)
					clus_start[8 * (cur_offset - CLUSTER_OFS) +: 8] = b;
				else if (cur_offset >= LENGTH_OFS)
					byte_length[8 * (cur_offset - LENGTH_OFS) +: 8] = b;
			end else if (cur_entry == EK_NAME && cur_offset >= NAME_CHR_OFS) begin
				// UTF-16 LE: low byte first, character complete on the high byte
				if (!cur_offset[0]) begin
					lo_hold = b;
				end else if (!name_done) begin
					if ({b, lo_hold} == 16'h0000) begin
						name_done = 1'b1;
					end else if (name_count < NAME_CAP) begin
						r = '0;
						r.kind = KIND_CHAR;
						r.name_char = lo_hold;
						byte_results.push_back(r);
						name_count++;
					end
				end
			end
			cur_offset = cur_offset + 5'd1;
		end
		// cluster end: close the group, next byte starts a fresh entry
		if (loc) begin
			if (!parse_halted && group_is_open)
				close_group();
			cur_offset = '0;
		end
		if (byte_results.size() > 0)
			byte_results[byte_results.size() - 1].last = 1'b1;
		foreach (byte_results[i])
			pending_results.push_back(byte_results[i]);
		byte_results.delete();
		return ignored;
	endfunction

	// ------------------------------------------------------------------
	// Byte channel driver: bursts of random length, random gaps between.
	// Inputs change on the falling edge; the transfer is seen on the rising
	// edge with valid and ready both high.
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic sod, input logic loc);
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			if (!gapless && $urandom_range(0, 3) != 0) begin
				byte_if.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		burst_left--;
		byte_if.valid <= 1'b1;
		byte_if.data_byte <= b;
		byte_if.start_of_dir <= sod;
		byte_if.last_of_cluster <= loc;
		@(posedge clk);
		while (!byte_if.ready)
			@(posedge clk);
		if (!parse_byte(b, sod, loc))
			bytes_parsed++;
	endtask

	// Send one entry. Clusters are a random number of whole entries; with
	// cuts enabled a cluster now and then ends part-way through an entry.
	task automatic send_entry(input entry_t e);
		int cut;
		bit at_end;
		bit stop;
		stop = 1'b0;
		cut = 32;
		if (cluster_cuts && $urandom_range(0, 39) == 0)
			cut = $urandom_range(0, 30);
		for (int i = 0; i < 32 && !stop; i++) begin
			at_end = (i == cut) || (i == 31 && cluster_left == 1);
			send_byte(e[i], sod_pending, at_end);
			sod_pending = 1'b0;
			stop = (i == cut);
		end
		if (stop || cluster_left == 1)
			cluster_left = $urandom_range(1, 8);
		else
			cluster_left--;
	endtask

	task automatic begin_directory();
		sod_pending = 1'b1;
	endtask

	// Drop valid, wait for every owed result, then let the pipe empty of
	// bytes that give no result.
	task automatic settle();
		@(negedge clk);
		byte_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic set_record_limit(input logic [15:0] value);
		settle();
		@(negedge clk);
		limit_we <= 1'b1;
		limit_wdata <= value;
		@(negedge clk);
		limit_we <= 1'b0;
		record_limit_val = value;
	endtask

	// ---- entry builders: random filler with the fields that matter set ----
	function automatic entry_t noise_entry();
		entry_t e;
		for (int i = 0; i < 32; i++)
			e[i] = 8'($urandom);
		return e;
	endfunction

	function automatic entry_t make_typed(input logic [7:0] etype);
		entry_t e;
		e = noise_entry();
		e[0] = etype;
		return e;
	endfunction

	function automatic entry_t make_file(input logic dir_set);
		entry_t e;
		e = make_typed(ET_FILE);
		e[ATTR_OFS][ATTR_DIR_BIT] = dir_set;
		return e;
	endfunction

	function automatic entry_t make_stream(input logic [31:0] cl, input logic [63:0] len);
		entry_t e;
		e = make_typed(ET_STREAM);
		for (int i = 0; i < 4; i++)
			e[CLUSTER_OFS + i] = cl[8 * i +: 8];
		for (int i = 0; i < 8; i++)
			e[LENGTH_OFS + i] = len[8 * i +: 8];
		return e;
	endfunction

	// n non-zero characters, then a zero character when n < 15; anything
	// after the zero is filler the parser must skip
	function automatic entry_t make_name(input int n);
		entry_t e;
		logic [7:0] lo;
		logic [7:0] hi;
		e = make_typed(ET_NAME);
		for (int k = 0; k < 15; k++) begin
			lo = 8'($urandom);
			hi = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
			if (k < n) begin
				if ($urandom_range(0, 15) == 0) begin
					// zero low byte, real character
					lo = 8'h00;
					hi = 8'($urandom_range(1, 255));
				end else if ({hi, lo} == 16'h0000) begin
					lo = 8'h41;
				end
			end else if (k == n) begin
				lo = 8'h00;
				hi = 8'h00;
			end
			e[NAME_CHR_OFS + 2 * k] = lo;
			e[NAME_CHR_OFS + 2 * k + 1] = hi;
		end
		return e;
	endfunction

	// any type byte the parser neither opens nor extends a group with, and not the end mark
	function automatic logic [7:0] junk_type();
		logic [7:0] t;
		do
			t = 8'($urandom);
		while (t == ET_END || t == ET_FILE || t == ET_STREAM || t == ET_NAME);
		return t;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Complete groups with every field at its top and bottom value.
	task automatic test_full_group();
		entry_t e;
		begin_directory();
		e = make_file(1'b1);
		e[ATTR_OFS] = 8'hFF;
		send_entry(e);
		send_entry(make_stream(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
		e = make_name(15);
		for (int k = NAME_CHR_OFS; k < 32; k++)
			e[k] = 8'hFF;
		send_entry(e);
		send_entry(make_typed(ET_END));
		begin_directory();
		e = make_file(1'b0);
		e[ATTR_OFS] = 8'hEF;
		send_entry(e);
		send_entry(make_stream('0, '0));
		send_entry(make_name(0));
		send_entry(make_typed(ET_END));
	endtask

	// Zero character ends only its own entry; a character with a zero low
	// byte still counts; a foreign entry type closes the group.
	task automatic test_name_rules();
		entry_t e;
		begin_directory();
		send_entry(make_file(1'b0));
		send_entry(make_stream($urandom, {$urandom, $urandom}));
		send_entry(make_name(3));
		send_entry(make_name(15));
		e = make_name(2);
		e[NAME_CHR_OFS] = 8'h00;
		e[NAME_CHR_OFS + 1] = 8'h80;
		send_entry(e);
		send_entry(make_typed(junk_type()));
		send_entry(make_typed(ET_END));
	endtask

	// Stray stream and name entries, a group with no stream, a cluster end
	// part-way into a name entry, and an end mark closing an open group.
	task automatic test_stray_and_closures();
		entry_t e;
		begin_directory();
		send_entry(make_typed(ET_STREAM));
		send_entry(make_typed(ET_NAME));
		send_entry(make_file(1'b0));
		send_entry(make_name(4));
		e = make_name(15);
		for (int i = 0; i < 10; i++)
			send_byte(e[i], 1'b0, i == 9);
		send_entry(make_file(1'b1));
		send_entry(make_stream($urandom, {$urandom, $urandom}));
		send_entry(make_name(5));
		send_entry(make_typed(ET_END));
		// halted: ignored until the next directory start
		send_entry(make_file(1'b1));
	endtask

	// More characters than a record can count: stops at the name cap.
	task automatic test_name_cap();
		begin_directory();
		send_entry(make_file(1'b1));
		send_entry(make_stream($urandom, {$urandom, $urandom}));
		repeat (18) send_entry(make_name(15));
		send_entry(make_typed(junk_type()));
		send_entry(make_typed(ET_END));
	endtask

	// A directory start inside a group drops that group with no record.
	task automatic test_restart_in_group();
		begin_directory();
		send_entry(make_file(1'b1));
		send_entry(make_stream($urandom, {$urandom, $urandom}));
		send_entry(make_name(3));
		begin_directory();
		send_entry(make_file(1'b0));
		send_entry(make_name(2));
		send_entry(make_typed(ET_END));
	endtask

	// Record limit at one and at its top value, and lowered to the count mid-group.
	task automatic test_record_limit();
		set_record_limit(16'd1);
		begin_directory();
		send_entry(make_file(1'b1));
		send_entry(make_stream($urandom, {$urandom, $urandom}));
		send_entry(make_typed(junk_type()));
		send_entry(make_file(1'b0));
		set_record_limit(16'hFFFF);
		begin_directory();
		send_entry(make_file(1'b0));
		send_entry(make_file(1'b1));
		send_entry(make_name(2));
		set_record_limit(16'd1);
		send_entry(make_typed(junk_type()));
		send_entry(make_file(1'b0));
	endtask

	// Long receiver hold while bytes keep coming back to back: the result
	// queue fills and the byte channel has to stall.
	task automatic test_backpressure();
		set_record_limit(16'hFFFF);
		gapless = 1'b1;
		hold_reqs++;
		begin_directory();
		repeat (3) begin
			send_entry(make_file(1'($urandom_range(0, 1))));
			send_entry(make_stream($urandom, {$urandom, $urandom}));
			repeat (3) send_entry(make_name(15));
		end
		send_entry(make_typed(ET_END));
		gapless = 1'b0;
	endtask

	// Mostly well-formed groups with random content; some strays, junk,
	// noise entries and directories left without an end mark.
	task automatic random_directory();
		begin_directory();
		repeat ($urandom_range(1, 5)) begin
			case ($urandom_range(0, 9))
				0: send_entry(make_typed($urandom_range(0, 1) ? ET_STREAM : ET_NAME));
				1: send_entry(noise_entry());
				2: send_entry(make_typed(junk_type()));
				default: ;
			endcase
			send_entry(make_file(1'($urandom_range(0, 1))));
			if ($urandom_range(0, 9) != 0)
				send_entry(make_stream($urandom,
					{$urandom, $urandom} >> $urandom_range(0, 63)));
			repeat ($urandom_range(0, 3)) send_entry(make_name($urandom_range(0, 15)));
		end
		if ($urandom_range(0, 4) != 0)
			send_entry(make_typed(ET_END));
	endtask

	task automatic test_random_traffic(input logic [15:0] limit, input int budget);
		int stop_at;
		set_record_limit(limit);
		stop_at = bytes_parsed + budget;
		while (bytes_parsed < stop_at)
			random_directory();
	endtask

	// ------------------------------------------------------------------
	// Result receiver: ready pattern changes at random intervals, including
	// stretches of always-ready; a long hold when asked.
	// ------------------------------------------------------------------
	initial begin : receiver_pacing
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_reqs != holds_done) begin
				holds_done++;
				res_if.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
			end else begin
				if (pace_count == 0) begin
					pace_count = $urandom_range(20, 120);
					pace_mode = $urandom_range(0, 3);
				end
				pace_count--;
				case (pace_mode)
					0: res_if.ready <= 1'b1;
					1: res_if.ready <= 1'($urandom_range(0, 1));
					2: res_if.ready <= (cycle_count % 5) < 3;
					default: res_if.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	function automatic void check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	// every result transfer against the oldest owed result
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result, kind %0d", res_if.kind);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 64'(want.kind), 64'(res_if.kind));
				check_field("name_char", 64'(want.name_char), 64'(res_if.name_char));
				check_field("is_directory", 64'(want.is_directory),
					64'(res_if.is_directory));
				check_field("start_cluster", 64'(want.start_cluster),
					64'(res_if.start_cluster));
				check_field("data_length", want.data_length, res_if.data_length);
				check_field("name_length", 64'(want.name_length), 64'(res_if.name_length));
				check_field("last", 64'(want.last), 64'(res_if.last));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$error("timed out with %0d results outstanding", pending_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		byte_if.valid = 1'b0;
		byte_if.data_byte = '0;
		byte_if.start_of_dir = 1'b0;
		byte_if.last_of_cluster = 1'b0;
		limit_we = 1'b0;
		limit_wdata = '0;
		clear_parser();
		record_limit_val = RECORD_LIMIT_RST;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part: without random cluster cuts
		test_full_group();
		test_name_rules();
		test_stray_and_closures();
		test_name_cap();
		test_restart_in_group();
		test_record_limit();
		test_backpressure();

		// random part, several record limits
		cluster_cuts = 1'b1;
		test_random_traffic(16'hFFFF, 500);
		test_random_traffic(16'($urandom_range(2, 6)), 250);
		test_random_traffic(RECORD_LIMIT_RST, 250);

		settle();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ----- dir_entry_set_parser.f -----
+incdir+rtl
rtl/desp_pkg.sv
rtl/desp_in_if.sv
rtl/desp_out_if.sv
rtl/desp_step.sv
rtl/desp_res_queue.sv
rtl/dir_entry_set_parser.sv
tb/tb.sv
